// ===== design/priority_run_queue_macros.svh =====
// ---------------------------------------------------------------------------
// priority_run_queue_macros.svh
// Assertion macros shared by the run queue RTL.
// ---------------------------------------------------------------------------
`ifndef PRIORITY_RUN_QUEUE_MACROS_SVH
`define PRIORITY_RUN_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, disabled while reset is asserted.
`define PRQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define PRQ_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define PRQ_ASSERT(label, clk, rst_n, prop, msg)
`define PRQ_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ===== design/prq_pkg.sv =====
// ---------------------------------------------------------------------------
// prq_pkg
// Types, codes and widths shared by the run queue modules.
// ---------------------------------------------------------------------------
`default_nettype none

package prq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int KIND_W   = 2;
    localparam int ID_W     = 8;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENQ   = 2'd0,
        KIND_PICK  = 2'd1,
        KIND_TICK  = 2'd2,
        KIND_STEAL = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 3'd0,
        STAT_IGNORED = 3'd1,
        STAT_EMPTY   = 3'd2,
        STAT_FULL    = 3'd3,
        STAT_NOCUR   = 3'd4
    } status_t;

    typedef enum logic {
        CTL_IDLE,
        CTL_EXEC
    } ctl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic exec;
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
    } ctl_sts_t;

    typedef struct packed {
        kind_t             kind;
        logic [ID_W-1:0]   task_id;
        logic [PRIO_W-1:0] task_prio;
        logic              insert_front;
        logic              was_runnable;
        logic              already_queued;
        logic              is_idle;
        logic              current_valid;
        logic [PRIO_W-1:0] current_prio;
    } req_t;

    typedef struct packed {
        logic              taken_valid;
        logic [ID_W-1:0]   taken_id;
        logic [PRIO_W-1:0] taken_prio;
        logic              resched;
        logic              mark_current_front;
        status_t           status;
    } rsp_t;

endpackage

`default_nettype wire

// ===== design/prq_ifs.sv =====
// ---------------------------------------------------------------------------
// prq_ifs
// Handshake channels of the run queue: event requests, results, config.
// ---------------------------------------------------------------------------
`default_nettype none

interface prq_req_if;
    import prq_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   task_id;
    logic [PRIO_W-1:0] task_prio;
    logic              insert_front;
    logic              was_runnable;
    logic              already_queued;
    logic              is_idle;
    logic              current_valid;
    logic [PRIO_W-1:0] current_prio;

    modport source (
        output valid, kind, task_id, task_prio, insert_front, was_runnable,
               already_queued, is_idle, current_valid, current_prio,
        input  ready
    );
    modport sink (
        input  valid, kind, task_id, task_prio, insert_front, was_runnable,
               already_queued, is_idle, current_valid, current_prio,
        output ready
    );
endinterface

interface prq_rsp_if;
    import prq_pkg::*;

    logic                valid;
    logic                ready;
    logic                taken_valid;
    logic [ID_W-1:0]     taken_id;
    logic [PRIO_W-1:0]   taken_prio;
    logic                resched;
    logic                mark_current_front;
    logic [STATUS_W-1:0] status;

    modport source (
        output valid, taken_valid, taken_id, taken_prio, resched,
               mark_current_front, status,
        input  ready
    );
    modport sink (
        input  valid, taken_valid, taken_id, taken_prio, resched,
               mark_current_front, status,
        output ready
    );
endinterface

interface prq_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== design/prq_ctrl.sv =====
// ---------------------------------------------------------------------------
// prq_ctrl
// Sequencer: captures one item, executes it once the result register is free.
// ---------------------------------------------------------------------------
`default_nettype none

`include "priority_run_queue_macros.svh"

module prq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output prq_pkg::ctl_cmd_t  cmd,
    input  prq_pkg::ctl_sts_t  sts
);
    import prq_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       out_free;

    assign out_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CTL_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = CTL_EXEC;
                end
            end
            CTL_EXEC:
            begin
                if (out_free)
                begin
                    state_next = CTL_IDLE;
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready   = 1'b0;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        unique case (state_reg)
            CTL_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            CTL_EXEC:
            begin
                cmd.exec = out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // load on execute, drop once the sink takes the item
    always_comb
    begin
        priority if (cmd.exec)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CTL_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    `PRQ_ASSERT(a_capture_to_exec, clk, rst_n, cmd.capture |=> state_reg == CTL_EXEC, "capture did not enter execute")
    `PRQ_ASSERT(a_exec_loads_rsp, clk, rst_n, cmd.exec |=> rsp_valid_reg, "execute did not present a result")
    `PRQ_ASSERT_NEVER(a_empty_and_full, clk, rst_n, sts.empty && sts.full, "queue reported empty and full")

endmodule

`default_nettype wire

// ===== design/prq_dpath.sv =====
// ---------------------------------------------------------------------------
// prq_dpath
// Sorted shift-register queue, event decode and result register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "priority_run_queue_macros.svh"

module prq_dpath #(
    parameter int QUEUE_DEPTH = prq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  prq_pkg::ctl_cmd_t cmd,
    output prq_pkg::ctl_sts_t sts,
    input  prq_pkg::req_t     req_data,
    input  logic              cfg_we,
    input  logic              cfg_data,
    output prq_pkg::rsp_t     rsp_data
);
    import prq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    req_t              q_reg;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;
    logic              preempt_reg;
    logic [CNT_W-1:0]  fill_count_reg;
    logic [CNT_W-1:0]  fill_count_next;
    logic [ID_W-1:0]   slot_id_reg   [QUEUE_DEPTH];
    logic [PRIO_W-1:0] slot_prio_reg [QUEUE_DEPTH];
    logic [ID_W-1:0]   slot_id_next  [QUEUE_DEPTH];
    logic [PRIO_W-1:0] slot_prio_next[QUEUE_DEPTH];

    logic [QUEUE_DEPTH-1:0] keep;
    logic                   q_empty;
    logic                   q_full;
    logic                   do_insert;
    logic                   do_pick;
    logic [CNT_W-1:0]       cnt_m1;
    logic [IDX_W-1:0]       tail_idx;

    assign q_empty  = fill_count_reg == '0;
    assign q_full   = fill_count_reg == CNT_W'(QUEUE_DEPTH);
    assign cnt_m1   = fill_count_reg - CNT_W'(1);
    assign tail_idx = cnt_m1[IDX_W-1:0];

    assign sts.empty = q_empty;
    assign sts.full  = q_full;

    // slots ahead of the insertion point; the queue is sorted so this is a prefix
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            keep[i] = (CNT_W'(i) < fill_count_reg) &&
                      (q_reg.insert_front ? (slot_prio_reg[i] < q_reg.task_prio)
                                          : (slot_prio_reg[i] <= q_reg.task_prio));
        end
    end

    always_comb
    begin
        rsp_next        = '0;
        rsp_next.status = STAT_OK;
        fill_count_next = fill_count_reg;
        do_insert       = 1'b0;
        do_pick         = 1'b0;
        unique case (q_reg.kind)
            KIND_ENQ:
            begin
                priority if (q_reg.already_queued || q_reg.is_idle)
                begin
                    rsp_next.status = STAT_IGNORED;
                end
                else if (q_full)
                begin
                    rsp_next.status = STAT_FULL;
                end
                else
                begin
                    do_insert       = 1'b1;
                    fill_count_next = fill_count_reg + CNT_W'(1);
                    if (!q_reg.was_runnable)
                    begin
                        priority if (!q_reg.current_valid)
                        begin
                            rsp_next.status = STAT_NOCUR;
                        end
                        else if (preempt_reg && (q_reg.task_prio < q_reg.current_prio))
                        begin
                            rsp_next.resched            = 1'b1;
                            rsp_next.mark_current_front = 1'b1;
                        end
                        else
                        begin
                            rsp_next.status = STAT_OK;
                        end
                    end
                end
            end
            KIND_PICK:
            begin
                if (q_empty)
                begin
                    rsp_next.status = STAT_EMPTY;
                end
                else
                begin
                    do_pick              = 1'b1;
                    fill_count_next      = cnt_m1;
                    rsp_next.taken_valid = 1'b1;
                    rsp_next.taken_id    = slot_id_reg[0];
                    rsp_next.taken_prio  = slot_prio_reg[0];
                end
            end
            KIND_TICK:
            begin
                rsp_next.resched = preempt_reg && q_reg.current_valid && !q_empty &&
                                   (slot_prio_reg[0] < q_reg.current_prio);
            end
            KIND_STEAL:
            begin
                if (q_empty)
                begin
                    rsp_next.status = STAT_EMPTY;
                end
                else
                begin
                    fill_count_next      = cnt_m1;
                    rsp_next.taken_valid = 1'b1;
                    rsp_next.taken_id    = slot_id_reg[tail_idx];
                    rsp_next.taken_prio  = slot_prio_reg[tail_idx];
                end
            end
            default:
            begin
                rsp_next.status = STAT_OK;
            end
        endcase
    end

    // insert: hold the prefix, write the new task at its edge, shift the rest back
    // pick: advance every slot toward the head
    always_comb
    begin
        slot_id_next   = slot_id_reg;
        slot_prio_next = slot_prio_reg;
        if (do_insert)
        begin
            if (!keep[0])
            begin
                slot_id_next[0]   = q_reg.task_id;
                slot_prio_next[0] = q_reg.task_prio;
            end
            for (int i = 1; i < QUEUE_DEPTH; i++)
            begin
                if (!keep[i])
                begin
                    if (keep[i-1])
                    begin
                        slot_id_next[i]   = q_reg.task_id;
                        slot_prio_next[i] = q_reg.task_prio;
                    end
                    else
                    begin
                        slot_id_next[i]   = slot_id_reg[i-1];
                        slot_prio_next[i] = slot_prio_reg[i-1];
                    end
                end
            end
        end
        else if (do_pick)
        begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                slot_id_next[i]   = slot_id_reg[i+1];
                slot_prio_next[i] = slot_prio_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            q_reg <= req_data;
        end
        if (cmd.exec)
        begin
            rsp_reg       <= rsp_next;
            slot_id_reg   <= slot_id_next;
            slot_prio_reg <= slot_prio_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            preempt_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                fill_count_reg <= fill_count_next;
            end
            if (cfg_we)
            begin
                preempt_reg <= cfg_data;
            end
        end
    end

    assign rsp_data = rsp_reg;

    `PRQ_ASSERT(a_fill_only_on_exec, clk, rst_n, !cmd.exec |=> $stable(fill_count_reg), "fill count moved without execute")
    `PRQ_ASSERT_NEVER(a_fill_overflow, clk, rst_n, fill_count_reg > CNT_W'(QUEUE_DEPTH), "fill count above depth")
    `PRQ_ASSERT(a_pick_decrements, clk, rst_n, cmd.exec && q_reg.kind == KIND_PICK && !q_empty |=> fill_count_reg == $past(fill_count_reg) - CNT_W'(1), "pick did not remove one task")

endmodule

`default_nettype wire

// ===== design/priority_run_queue.sv =====
// ---------------------------------------------------------------------------
// priority_run_queue
// Per-CPU run queue kept sorted by priority (lower value is more urgent).
// ---------------------------------------------------------------------------
// Usage:
//   req carries one scheduler event (enqueue, pick, tick, steal) and the
//   task and current-task fields; rsp returns exactly one result item per
//   event (removed task, resched, mark_current_front, status).
//   cfg writes preemption_enabled; write only while no event is pending.
// Sequencing:
//   An event is captured at the req handshake and executed once the
//   output register is free, which registers its result. The block takes
//   no new event until the last one has executed: a capture step, then an
//   execute step, in which all queue slots compare and shift in parallel.
// Reset:
//   The queue is empty, preemption is disabled and rsp holds no item.
//   Slot contents are not cleared; only occupied slots are ever read.
// Back-pressure:
//   A result waits in the output register while rsp.ready is low. One more
//   event may be captured meanwhile; it executes once that result is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module priority_run_queue #(
    parameter int QUEUE_DEPTH = prq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    prq_cfg_if.sink  cfg,
    prq_req_if.sink  req,
    prq_rsp_if.source rsp
);
    import prq_pkg::*;

    ctl_cmd_t cmd;
    ctl_sts_t sts;
    req_t     req_data;
    rsp_t     rsp_data;
    logic     req_ready;
    logic     rsp_valid;

    assign cfg.ready = 1'b1;

    assign req_data.kind           = kind_t'(req.kind);
    assign req_data.task_id        = req.task_id;
    assign req_data.task_prio      = req.task_prio;
    assign req_data.insert_front   = req.insert_front;
    assign req_data.was_runnable   = req.was_runnable;
    assign req_data.already_queued = req.already_queued;
    assign req_data.is_idle        = req.is_idle;
    assign req_data.current_valid  = req.current_valid;
    assign req_data.current_prio   = req.current_prio;

    prq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    prq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .req_data (req_data),
        .cfg_we   (cfg.valid),
        .cfg_data (cfg.data),
        .rsp_data (rsp_data)
    );

    assign req.ready              = req_ready;
    assign rsp.valid              = rsp_valid;
    assign rsp.taken_valid        = rsp_data.taken_valid;
    assign rsp.taken_id           = rsp_data.taken_id;
    assign rsp.taken_prio         = rsp_data.taken_prio;
    assign rsp.resched            = rsp_data.resched;
    assign rsp.mark_current_front = rsp_data.mark_current_front;
    assign rsp.status             = rsp_data.status;

endmodule

`default_nettype wire
